>>> src/cubic_spline_evaluator_macros.svh
// ----------------------------------------------------------------------------
// cubic spline evaluator assertion macros
// same-cycle and next-cycle implication checks on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef CUBIC_SPLINE_EVALUATOR_MACROS_SVH
`define CUBIC_SPLINE_EVALUATOR_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CSE_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cse check failed");

// antecedent implies consequent in the next cycle
`define CSE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cse check failed");

`endif

>>> src/cse_pkg.sv
// ----------------------------------------------------------------------------
// cse_pkg
// shared types, widths, codes and saturation for the cubic spline evaluator
// ----------------------------------------------------------------------------
package cse_pkg;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 4;
  localparam int CNT_W  = 5;
  localparam int ORD_W  = 2;

  localparam int DEF_MAX_KNOTS = 16;
  localparam int DEF_FRAC_BITS = 16;

  // datapath widths of the shared multiply-accumulate unit
  localparam int DX_W   = DATA_W + 1;
  localparam int ADD_W  = DATA_W + 2;
  localparam int PROD_W = DATA_W + DX_W;
  localparam int SUM_W  = PROD_W + 1;

  // operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // derivative orders, order three gives a zero result
  localparam logic [ORD_W-1:0] ORD_VALUE  = 2'd0;
  localparam logic [ORD_W-1:0] ORD_FIRST  = 2'd1;
  localparam logic [ORD_W-1:0] ORD_SECOND = 2'd2;
  localparam logic [ORD_W-1:0] ORD_NONE   = 2'd3;

  localparam logic [CNT_W-1:0] KNOT_COUNT_RST = 5'd2;

  typedef struct packed {
    logic                     operation;
    logic [IDX_W-1:0]         entry_index;
    logic signed [DATA_W-1:0] knot_position;
    logic signed [DATA_W-1:0] coef_const;
    logic signed [DATA_W-1:0] coef_linear;
    logic signed [DATA_W-1:0] coef_square;
    logic signed [DATA_W-1:0] coef_cube;
    logic signed [DATA_W-1:0] query_position;
    logic [ORD_W-1:0]         derivative_order;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic                     out_of_range;
  } out_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] knot;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic signed [DATA_W-1:0] c;
    logic signed [DATA_W-1:0] d;
  } tbl_entry_t;

  // clamp a wide signed value to the signed data range
  function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] max_v;
    logic signed [SUM_W-1:0] min_v;
    max_v = {{(SUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    min_v = {{(SUM_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
    if (v > max_v) begin
      return max_v[DATA_W-1:0];
    end else if (v < min_v) begin
      return min_v[DATA_W-1:0];
    end else begin
      return v[DATA_W-1:0];
    end
  endfunction

endpackage

>>> src/cubic_spline_evaluator.sv
// load: an accepted load with an index below MAX_KNOTS writes its table row; the sequencer stays idle
// query: a scan over the n rows of the clamped knot count, a fetch of the segment row, then k = 3 - order
//   Horner steps (k = 0 out of range), each an issue to the multiply unit and a wait for its result
// one item at a time; the scan reads one table row per cycle and the result waits while the output stalls
// reset: sequencer idle, no result pending, knot count 2; the table is undefined until loaded
// ----------------------------------------------------------------------------
// cubic_spline_evaluator
// piecewise cubic spline value and derivative evaluation from a loaded table
// ----------------------------------------------------------------------------
`include "cubic_spline_evaluator_macros.svh"

module cubic_spline_evaluator #(
  parameter int MAX_KNOTS = cse_pkg::DEF_MAX_KNOTS,
  parameter int FRAC_BITS = cse_pkg::DEF_FRAC_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  cse_pkg::in_item_t               in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output cse_pkg::out_item_t              out_item_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [cse_pkg::CNT_W-1:0]       cfg_data_i
);
  import cse_pkg::*;

  localparam int AW = $clog2(MAX_KNOTS);
  localparam int CW = $clog2(MAX_KNOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FETCH,
    S_ISSUE,
    S_WAIT,
    S_OUT
  } state_e;

  state_e                   state_q, state_d;
  logic [AW-1:0]            addr_q, addr_d;
  logic [AW-1:0]            seg_q, seg_d;
  logic                     oor_q, oor_d;
  logic signed [DATA_W-1:0] t_q, t_d;
  logic [ORD_W-1:0]         order_q, order_d;
  logic signed [DX_W-1:0]   dx_q, dx_d;
  logic signed [DATA_W-1:0] r_q, r_d;
  logic [1:0]               step_q, step_d;
  logic                     out_valid_q, out_valid_d;
  out_item_t                out_item_q, out_item_d;
  logic [CNT_W-1:0]         knot_cnt_q;

  logic                     in_accept;
  logic [31:0]              idx_wide;
  logic                     tbl_we;
  tbl_entry_t               tbl_wdata;
  tbl_entry_t               rdata;
  logic [CW-1:0]            n_knots;
  logic [AW-1:0]            last_idx;
  logic [AW-1:0]            seg_max;
  logic                     ge;
  logic [AW-1:0]            seg_nx;
  logic signed [SUM_W-1:0]  d_ext, d3, d6;
  logic signed [ADD_W-1:0]  c_ext, addend;
  logic                     mac_start;
  logic                     mac_done;
  logic signed [DATA_W-1:0] mac_res;

  // handshakes
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = (state_q == S_IDLE);

  // knot count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      knot_cnt_q <= KNOT_COUNT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      knot_cnt_q <= cfg_data_i;
    end
  end

  // clamped knot count and derived indexes
  always_comb begin
    if (knot_cnt_q < CNT_W'(2)) begin
      n_knots = CW'(2);
    end else if (32'(knot_cnt_q) > MAX_KNOTS) begin
      n_knots = CW'(MAX_KNOTS);
    end else begin
      n_knots = CW'(knot_cnt_q);
    end
  end
  assign last_idx = AW'(n_knots - CW'(1));
  assign seg_max  = AW'(n_knots - CW'(2));

  // table load path
  assign idx_wide = 32'(in_item_i.entry_index);
  assign tbl_we   = in_accept && (in_item_i.operation == OP_LOAD) && (idx_wide < MAX_KNOTS);
  assign tbl_wdata = '{knot: in_item_i.knot_position, a: in_item_i.coef_const,
                       b: in_item_i.coef_linear, c: in_item_i.coef_square,
                       d: in_item_i.coef_cube};

  cse_table #(
    .MAX_KNOTS (MAX_KNOTS),
    .AW        (AW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (idx_wide[AW-1:0]),
    .wdata_i (tbl_wdata),
    .raddr_i (addr_d),
    .rdata_o (rdata)
  );

  // scan compare against the row at addr_q
  assign ge     = (t_q >= rdata.knot);
  assign seg_nx = ge ? addr_q : seg_q;

  // scaled cubic term for derivative starts
  assign d_ext = SUM_W'(signed'(rdata.d));
  assign d3    = d_ext + (d_ext <<< 1);
  assign d6    = d3 <<< 1;

  // horner addend for the current step
  assign c_ext = ADD_W'(signed'(rdata.c));
  always_comb begin
    case (step_q)
      2'd0:    addend = (order_q == ORD_VALUE) ? c_ext : (c_ext <<< 1);
      2'd1:    addend = ADD_W'(signed'(rdata.b));
      default: addend = ADD_W'(signed'(rdata.a));
    endcase
  end

  assign mac_start = (state_q == S_ISSUE);

  cse_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mac_start),
    .acc_i   (r_q),
    .dx_i    (dx_q),
    .add_i   (addend),
    .done_o  (mac_done),
    .res_o   (mac_res)
  );

  // sequencer next state
  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    seg_d       = seg_q;
    oor_d       = oor_q;
    t_d         = t_q;
    order_d     = order_q;
    dx_d        = dx_q;
    r_d         = r_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept && (in_item_i.operation == OP_EVAL)) begin
          t_d     = in_item_i.query_position;
          order_d = in_item_i.derivative_order;
          addr_d  = '0;
          seg_d   = '0;
          oor_d   = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        seg_d = seg_nx;
        oor_d = oor_q || ((addr_q == '0) && !ge) || ((addr_q == last_idx) && (t_q > rdata.knot));
        if (addr_q == last_idx) begin
          addr_d  = (seg_nx > seg_max) ? seg_max : seg_nx;
          state_d = S_FETCH;
        end else begin
          addr_d = addr_q + AW'(1);
        end
      end
      S_FETCH: begin
        dx_d   = DX_W'(signed'(t_q)) - DX_W'(signed'(rdata.knot));
        step_d = 2'd0;
        if (oor_q) begin
          r_d     = '0;
          state_d = S_OUT;
        end else begin
          case (order_q)
            ORD_VALUE: begin
              r_d     = rdata.d;
              state_d = S_ISSUE;
            end
            ORD_FIRST: begin
              r_d     = sat_data(d3);
              state_d = S_ISSUE;
            end
            ORD_SECOND: begin
              r_d     = sat_data(d6);
              state_d = S_ISSUE;
            end
            default: begin
              r_d     = '0;
              state_d = S_OUT;
            end
          endcase
        end
      end
      S_ISSUE: begin
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (mac_done) begin
          r_d = mac_res;
          if (step_q == (2'd2 - order_q)) begin
            state_d = S_OUT;
          end else begin
            step_d  = step_q + 2'd1;
            state_d = S_ISSUE;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_item_d  = '{result_value: r_q, out_of_range: oor_q};
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // sequencer registers and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      addr_q      <= '0;
      seg_q       <= '0;
      oor_q       <= 1'b0;
      t_q         <= '0;
      order_q     <= '0;
      dx_q        <= '0;
      r_q         <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      seg_q       <= seg_d;
      oor_q       <= oor_d;
      t_q         <= t_d;
      order_q     <= order_d;
      dx_q        <= dx_d;
      r_q         <= r_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      out_item_q  <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // checks
  `CSE_ASSERT_NEXT(a_query_starts_scan, in_accept && (in_item_i.operation == OP_EVAL), (state_q == S_SCAN) && (addr_q == '0))
  `CSE_ASSERT_SAME(a_scan_in_bounds, state_q == S_SCAN, addr_q <= last_idx)
  `CSE_ASSERT_SAME(a_mac_done_expected, mac_done, state_q == S_WAIT)
  `CSE_ASSERT_SAME(a_oor_zero_result, out_valid_o && out_item_o.out_of_range, out_item_o.result_value == '0)

endmodule

>>> src/cse_table.sv
// ----------------------------------------------------------------------------
// cse_table
// knot and coefficient storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module cse_table #(
  parameter int MAX_KNOTS = cse_pkg::DEF_MAX_KNOTS,
  parameter int AW        = $clog2(MAX_KNOTS)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  cse_pkg::tbl_entry_t wdata_i,
  input  logic [AW-1:0]       raddr_i,
  output cse_pkg::tbl_entry_t rdata_o
);
  import cse_pkg::*;

  tbl_entry_t mem [MAX_KNOTS];
  tbl_entry_t rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/cse_mac.sv
// ----------------------------------------------------------------------------
// cse_mac
// shared two-stage unit: sat(addend + round(acc * dx)) in fixed point
// ----------------------------------------------------------------------------
module cse_mac #(
  parameter int FRAC_BITS = cse_pkg::DEF_FRAC_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [cse_pkg::DATA_W-1:0]    acc_i,
  input  logic signed [cse_pkg::DX_W-1:0]      dx_i,
  input  logic signed [cse_pkg::ADD_W-1:0]     add_i,
  output logic                                 done_o,
  output logic signed [cse_pkg::DATA_W-1:0]    res_o
);
  import cse_pkg::*;

  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(64'sd1 <<< (FRAC_BITS - 1));

  logic                      vld1_q;
  logic                      vld2_q;
  logic signed [PROD_W-1:0]  prod_d;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [ADD_W-1:0]   add_q;
  logic signed [SUM_W-1:0]   sum_d;
  logic signed [DATA_W-1:0]  res_q;

  // stage one product
  assign prod_d = acc_i * dx_i;

  // stage two round half up, add and saturate
  assign sum_d = SUM_W'(add_q) + ((SUM_W'(prod_q) + HALF) >>> FRAC_BITS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      prod_q <= '0;
      add_q  <= '0;
      res_q  <= '0;
    end else begin
      vld1_q <= start_i;
      vld2_q <= vld1_q;
      if (start_i) begin
        prod_q <= prod_d;
        add_q  <= add_i;
      end
      if (vld1_q) begin
        res_q <= sat_data(sum_d);
      end
    end
  end

  assign done_o = vld2_q;
  assign res_o  = res_q;

endmodule
